### rtl/ricart_agrawala_mutex_node_core_defines.svh
// Assertion macros shared by the mutex node checker.
`ifndef RICART_AGRAWALA_MUTEX_NODE_CORE_DEFINES_SVH
`define RICART_AGRAWALA_MUTEX_NODE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define RAG_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define RAG_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rag_pkg.sv
// Types and constants for the Ricart-Agrawala mutex node.
package rag_pkg;

    localparam int NODE_ID_W = 6;
    localparam int CLOCK_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int QADDR_W   = 4;
    localparam int QDEPTH    = 16;
    localparam int QCNT_W    = 5;

    localparam logic [QCNT_W-1:0]  QLIMIT    = 5'd15;
    localparam logic [COUNT_W-1:0] REPLY_MAX = 7'h7f;

    typedef enum logic [2:0] {
        CMD_REQUEST = 3'd0,
        CMD_REPLY   = 3'd1,
        CMD_WANT    = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_OTHER   = 3'd4
    } t_cmd;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_ENTER   = 2'd2;

    localparam logic CFG_MY_NODE    = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_WANTED   = 2'd1,
        MODE_HELD     = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ONE   = 2'd1,
        ACT_WALK  = 2'd2,
        ACT_DRAIN = 2'd3
    } t_act;

    typedef struct packed {
        logic [2:0]           command;
        logic [NODE_ID_W-1:0] from_node;
        logic [CLOCK_W-1:0]   msg_clock;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           msg_kind;
        logic [NODE_ID_W-1:0] dest_node;
        logic [CLOCK_W-1:0]   out_clock;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic walk_step;
        logic drain_step;
    } t_ctrl_cmd;

    typedef struct packed {
        t_act act;
        logic out_free;
        logic walk_last;
        logic drain_last;
    } t_ctrl_status;

endpackage

### rtl/ricart_agrawala_mutex_node_core.sv
// Top level of one Ricart-Agrawala mutual exclusion node.
//
// Input channel (i_in_valid / o_in_stall, i_in_data) takes one transaction per
// command: request or reply arrived, local want, local release, other message.
// Output channel (o_out_valid / i_out_stall, o_out_data) carries the messages
// to send and the enter notice; last marks the final result of a command.
// Configuration: i_cfg_we writes my_node (index 0) or node_count (index 1).
// Timing: a single result appears in the output register in the cycle after the
// command is taken. A want walks the peers, one request per cycle while the
// receiver does not stall, n-1 requests for n live nodes; a release walks the
// deferred queue, one reply per cycle while the receiver does not stall, up to
// 15 replies. A command with no result does not hold the input.
// While a walk runs, o_in_stall stays high. When the receiver stalls, the
// output register holds its result and the walk waits.
// Reset clears the clock, mode, counters and the queue fill count, and sets
// my_node to 0 and node_count to 2; queue contents are not cleared.
module ricart_agrawala_mutex_node_core import rag_pkg::*; #(
    parameter int NODES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    rag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rag_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/rag_ctrl.sv
// Sequencer: accepts transactions and steps the request walk and the release drain.
module rag_ctrl import rag_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.out_free) begin
                    if (i_status.act == ACT_WALK) begin
                        n_state = ST_WALK;
                    end else if (i_status.act == ACT_DRAIN) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_WALK: begin
                if (i_status.out_free && i_status.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free && i_status.drain_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
            end
            ST_WALK:  o_cmd.walk_step  = i_status.out_free;
            ST_DRAIN: o_cmd.drain_step = i_status.out_free;
            default: ;
        endcase
    end

endmodule

### rtl/rag_dp.sv
// Datapath: Lamport clock, node state, deferred queue, peer walk and output register.
module rag_dp import rag_pkg::*; #(
    parameter int NODES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [6:0]   i_cfg_data,
    input  t_in_item     i_in_data,
    input  logic         i_out_stall,
    input  t_ctrl_cmd    i_cmd,
    output t_ctrl_status o_status,
    output logic         o_out_valid,
    output t_out_item    o_out_data
);

    localparam logic [COUNT_W-1:0] NODES_N = COUNT_W'(NODES);

    logic [NODE_ID_W-1:0] r_my_node;
    logic [COUNT_W-1:0]   r_node_count;
    logic [CLOCK_W-1:0]   r_clock,     n_clock;
    t_mode                r_mode,      n_mode;
    logic [CLOCK_W-1:0]   r_stamp,     n_stamp;
    logic [COUNT_W-1:0]   r_reply_cnt, n_reply_cnt;
    logic [QCNT_W-1:0]    r_qcount,    n_qcount;
    logic [QADDR_W-1:0]   r_rd_idx,    n_rd_idx;
    logic [COUNT_W-1:0]   r_id,        n_id;
    logic [COUNT_W-1:0]   r_sent,      n_sent;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data,  n_out_data;
    logic [NODE_ID_W-1:0] r_rd_data;
    logic [NODE_ID_W-1:0] r_queue [QDEPTH];

    logic [COUNT_W-1:0]   live_n;
    logic [COUNT_W-1:0]   peers;
    logic [CLOCK_W-1:0]   max_clk;
    logic [CLOCK_W-1:0]   raised;
    logic [CLOCK_W-1:0]   bumped;
    logic [COUNT_W-1:0]   reply_inc;
    logic                 defer;
    logic                 enter_now;
    t_act                 act;
    t_out_item            one_item;
    logic [COUNT_W-1:0]   emit_id;
    logic                 walk_last;
    logic                 drain_last;
    logic                 q_we;
    logic                 rd_en;
    logic [QADDR_W-1:0]   rd_addr;

    always_comb begin
        if (r_node_count == '0) begin
            live_n = COUNT_W'(1);
        end else if (r_node_count > NODES_N) begin
            live_n = NODES_N;
        end else begin
            live_n = r_node_count;
        end
        peers     = live_n - COUNT_W'(1);
        max_clk   = (i_in_data.msg_clock > r_clock) ? i_in_data.msg_clock : r_clock;
        raised    = max_clk + CLOCK_W'(1);
        bumped    = r_clock + CLOCK_W'(1);
        reply_inc = (r_reply_cnt != REPLY_MAX) ? r_reply_cnt + COUNT_W'(1) : r_reply_cnt;
        defer     = (r_mode == MODE_HELD) ||
                    ((r_mode == MODE_WANTED) &&
                     ((i_in_data.msg_clock > r_stamp) ||
                      ((i_in_data.msg_clock == r_stamp) &&
                       (i_in_data.from_node > r_my_node))));
        enter_now = (r_mode == MODE_WANTED) && (reply_inc >= peers);

        act      = ACT_NONE;
        one_item = '{msg_kind: KIND_ENTER, dest_node: r_my_node,
                     out_clock: raised, last: 1'b1};
        case (i_in_data.command)
            CMD_REQUEST: begin
                if (!defer) begin
                    act      = ACT_ONE;
                    one_item = '{msg_kind: KIND_REPLY, dest_node: i_in_data.from_node,
                                 out_clock: raised + CLOCK_W'(1), last: 1'b1};
                end
            end
            CMD_REPLY: begin
                if (enter_now) begin
                    act = ACT_ONE;
                end
            end
            CMD_WANT: begin
                if (r_mode == MODE_RELEASED) begin
                    if (peers == '0) begin
                        act                = ACT_ONE;
                        one_item.out_clock = bumped;
                    end else begin
                        act = ACT_WALK;
                    end
                end
            end
            CMD_RELEASE: begin
                if (r_mode == MODE_HELD && r_qcount != '0) begin
                    act = ACT_DRAIN;
                end
            end
            default: act = ACT_NONE;
        endcase

        emit_id    = (r_id == COUNT_W'(r_my_node)) ? r_id + COUNT_W'(1) : r_id;
        walk_last  = (r_sent + COUNT_W'(1)) == peers;
        drain_last = (QCNT_W'(r_rd_idx) + QCNT_W'(1)) == r_qcount;
    end

    always_comb begin
        o_status.act        = act;
        o_status.out_free   = !r_out_valid || !i_out_stall;
        o_status.walk_last  = walk_last;
        o_status.drain_last = drain_last;
    end

    always_comb begin
        n_clock     = r_clock;
        n_mode      = r_mode;
        n_stamp     = r_stamp;
        n_reply_cnt = r_reply_cnt;
        n_qcount    = r_qcount;
        n_rd_idx    = r_rd_idx;
        n_id        = r_id;
        n_sent      = r_sent;
        q_we        = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        if (i_cmd.accept) begin
            case (i_in_data.command)
                CMD_REQUEST: begin
                    if (defer) begin
                        n_clock = raised;
                        if (r_qcount < QLIMIT) begin
                            q_we     = 1'b1;
                            n_qcount = r_qcount + QCNT_W'(1);
                        end
                    end else begin
                        n_clock = raised + CLOCK_W'(1);
                    end
                end
                CMD_REPLY: begin
                    n_clock = raised;
                    if (r_mode == MODE_WANTED) begin
                        if (enter_now) begin
                            n_mode      = MODE_HELD;
                            n_reply_cnt = '0;
                            n_stamp     = '0;
                        end else begin
                            n_reply_cnt = reply_inc;
                        end
                    end
                end
                CMD_WANT: begin
                    if (r_mode == MODE_RELEASED) begin
                        n_clock     = bumped;
                        n_reply_cnt = '0;
                        n_id        = '0;
                        n_sent      = '0;
                        if (peers == '0) begin
                            n_mode  = MODE_HELD;
                            n_stamp = '0;
                        end else begin
                            n_mode  = MODE_WANTED;
                            n_stamp = bumped;
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (r_mode == MODE_HELD) begin
                        n_clock  = r_clock + CLOCK_W'(2);
                        n_mode   = MODE_RELEASED;
                        n_rd_idx = '0;
                        rd_en    = 1'b1;
                    end
                end
                CMD_OTHER: n_clock = raised;
                default: ;
            endcase
            if (act == ACT_ONE) begin
                n_out_valid = 1'b1;
                n_out_data  = one_item;
            end
        end

        if (i_cmd.walk_step) begin
            n_out_valid = 1'b1;
            n_out_data  = '{msg_kind: KIND_REQUEST, dest_node: emit_id[NODE_ID_W-1:0],
                            out_clock: r_stamp, last: walk_last};
            n_id        = emit_id + COUNT_W'(1);
            n_sent      = r_sent + COUNT_W'(1);
        end

        if (i_cmd.drain_step) begin
            n_out_valid = 1'b1;
            n_out_data  = '{msg_kind: KIND_REPLY, dest_node: r_rd_data,
                            out_clock: r_clock, last: drain_last};
            n_rd_idx    = r_rd_idx + QADDR_W'(1);
            rd_en       = 1'b1;
            rd_addr     = r_rd_idx + QADDR_W'(1);
            if (drain_last) begin
                n_qcount = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_node    <= '0;
            r_node_count <= COUNT_W'(2);
            r_clock      <= '0;
            r_mode       <= MODE_RELEASED;
            r_stamp      <= '0;
            r_reply_cnt  <= '0;
            r_qcount     <= '0;
            r_rd_idx     <= '0;
            r_id         <= '0;
            r_sent       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MY_NODE:    r_my_node    <= i_cfg_data[NODE_ID_W-1:0];
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    default: ;
                endcase
            end
            r_clock     <= n_clock;
            r_mode      <= n_mode;
            r_stamp     <= n_stamp;
            r_reply_cnt <= n_reply_cnt;
            r_qcount    <= n_qcount;
            r_rd_idx    <= n_rd_idx;
            r_id        <= n_id;
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (q_we) begin
            r_queue[r_qcount[QADDR_W-1:0]] <= i_in_data.from_node;
        end
        if (rd_en) begin
            r_rd_data <= r_queue[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/rag_chk.sv
// Port-level checker for the mutex node, bound to the top level.
`include "ricart_agrawala_mutex_node_core_defines.svh"

module rag_chk import rag_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic                       rst_act;
    logic                       out_hold;
    logic                       burst_go;
    logic                       mid_burst;
    logic                       kind_ok;
    logic [$bits(t_out_item):0] out_word;

    assign rst_act   = !i_rst_n;
    assign out_hold  = o_out_valid && i_out_stall;
    assign burst_go  = o_out_valid && !i_out_stall && !o_out_data.last;
    assign mid_burst = o_out_valid && !o_out_data.last;
    assign kind_ok   = (o_out_data.msg_kind == KIND_REQUEST) ||
                       (o_out_data.msg_kind == KIND_REPLY) ||
                       (o_out_data.msg_kind == KIND_ENTER);
    assign out_word  = {o_out_valid, o_out_data};

    `RAG_ASSERT_NEXT(a_out_hold, i_clk, rst_act, out_hold, $stable(out_word), "output changed")
    `RAG_ASSERT_NEXT(a_rst_clear, i_clk, 1'b0, rst_act, !o_out_valid, "valid after reset")
    `RAG_ASSERT_NOW(a_kind_legal, i_clk, rst_act, o_out_valid, kind_ok, "illegal message kind")
    `RAG_ASSERT_NOW(a_busy_stall, i_clk, rst_act, mid_burst, o_in_stall, "input open mid burst")
    `RAG_ASSERT_NEXT(a_walk_cont, i_clk, rst_act, burst_go, o_out_valid, "gap inside a burst")

endmodule

bind ricart_agrawala_mutex_node_core rag_chk u_rag_chk (.*);

### verif/tb_ricart_agrawala_mutex_node_core.sv
// Self-checking testbench for one Ricart-Agrawala mutex node core.
module tb_ricart_agrawala_mutex_node_core;
    import rag_pkg::*;

    localparam int          NODES        = 16;
    localparam logic [2:0]  CMD_CODE_MAX = 3'd7;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE_WAIT  = 24;
    localparam int          PHASE_CMDS   = 30;
    localparam longint      RUN_LIMIT    = 64'd6_000_000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic       cfg_idx    = 1'b0;
    logic [6:0] cfg_data   = 7'd0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    t_in_item   in_data    = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    t_out_item  out_data;

    ricart_agrawala_mutex_node_core #(
        .NODES(NODES)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // node state as predicted
    logic [5:0]  cfg_id      = 6'd0;
    logic [6:0]  cfg_cnt     = 7'd2;
    logic [31:0] lamport     = 32'd0;
    t_mode       node_state  = MODE_RELEASED;
    logic [31:0] own_stamp   = 32'd0;
    logic [6:0]  reply_tally = 7'd0;
    logic [5:0]  defer_ids [QDEPTH];
    logic [4:0]  defer_fill  = 5'd0;

    t_in_item    cmds_pending [$];
    t_out_item   sends_due    [$];
    t_out_item   step_sends   [$];

    int unsigned cmds_queued   = 0;
    int unsigned cmds_taken    = 0;
    int unsigned sends_checked = 0;
    int unsigned entries       = 0;
    int unsigned dropped       = 0;
    int unsigned settings_used = 1;
    int unsigned errs          = 0;

    bit          cmd_taken  = 1'b0;
    bit          quiet      = 1'b0;
    bit          hold_start = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned hold_left  = 0;
    int unsigned burst_left = 0;
    int unsigned calm_left  = 0;

    function automatic int unsigned live_count();
        int unsigned n;
        n = 32'(cfg_cnt);
        if (n < 1) n = 1;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    function automatic t_out_item mk_send(logic [1:0] kind, logic [5:0] dest,
                                          logic [31:0] stamp);
        t_out_item r;
        r.msg_kind  = kind;
        r.dest_node = dest;
        r.out_clock = stamp;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic void bump_clock(logic [31:0] mc);
        if (mc > lamport) lamport = mc;
        lamport = lamport + 32'd1;
    endfunction

    function automatic void enter_if_ready();
        if (node_state == MODE_WANTED && 32'(reply_tally) >= live_count() - 1) begin
            step_sends.push_back(mk_send(KIND_ENTER, cfg_id, lamport));
            node_state  = MODE_HELD;
            reply_tally = 7'd0;
            own_stamp   = 32'd0;
            entries++;
        end
    endfunction

    task automatic compute_sends(input t_in_item it);
        logic [31:0] mc;
        logic        postpone;
        int unsigned n;
        int unsigned sent;
        t_out_item   tail;
        mc = it.msg_clock;
        step_sends = {};
        case (it.command)
            CMD_REQUEST: begin
                bump_clock(mc);
                postpone = (node_state == MODE_HELD) ||
                           (node_state == MODE_WANTED &&
                            (mc > own_stamp || (mc == own_stamp && it.from_node > cfg_id)));
                if (postpone) begin
                    if (defer_fill < QLIMIT) begin
                        defer_ids[defer_fill[3:0]] = it.from_node;
                        defer_fill = defer_fill + 5'd1;
                    end else begin
                        dropped++;
                    end
                end else begin
                    lamport = lamport + 32'd1;
                    step_sends.push_back(mk_send(KIND_REPLY, it.from_node, lamport));
                end
            end
            CMD_REPLY: begin
                bump_clock(mc);
                if (node_state == MODE_WANTED) begin
                    if (reply_tally < REPLY_MAX) reply_tally = reply_tally + 7'd1;
                    enter_if_ready();
                end
            end
            CMD_WANT: begin
                if (node_state == MODE_RELEASED) begin
                    n = live_count();
                    sent = 0;
                    lamport = lamport + 32'd1;
                    own_stamp = lamport;
                    node_state = MODE_WANTED;
                    reply_tally = 7'd0;
                    for (int id = 0; id < n && sent < n - 1; id++) begin
                        if (id != int'(cfg_id)) begin
                            step_sends.push_back(mk_send(KIND_REQUEST, 6'(id), own_stamp));
                            sent++;
                        end
                    end
                    enter_if_ready();
                end
            end
            CMD_RELEASE: begin
                if (node_state == MODE_HELD) begin
                    lamport = lamport + 32'd2;
                    node_state = MODE_RELEASED;
                    for (int i = 0; i < int'(defer_fill); i++)
                        step_sends.push_back(mk_send(KIND_REPLY, defer_ids[4'(i)], lamport));
                    defer_fill = 5'd0;
                end
            end
            CMD_OTHER: bump_clock(mc);
            default: ;
        endcase
        if (step_sends.size() > 0) begin
            tail = step_sends.pop_back();
            tail.last = 1'b1;
            step_sends.push_back(tail);
        end
        foreach (step_sends[i]) sends_due.push_back(step_sends[i]);
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errs++;
        end
    endfunction

    // monitor: config writes, accepted commands, results
    always @(posedge clk) begin : monitor
        t_out_item due;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_idx == CFG_MY_NODE) cfg_id = cfg_data[5:0];
                else                         cfg_cnt = cfg_data;
            end
            if (in_valid && !in_stall) begin
                compute_sends(in_data);
                cmds_taken++;
                cmd_taken = 1'b1;
            end
            if (out_valid && !out_stall) begin
                sends_checked++;
                if (sends_due.size() == 0) begin
                    $error("result with no transaction pending: kind %0d dest %0d clock %0d",
                           out_data.msg_kind, out_data.dest_node, out_data.out_clock);
                    errs++;
                end else begin
                    due = sends_due.pop_front();
                    cmp_field("msg_kind", 32'(due.msg_kind), 32'(out_data.msg_kind));
                    cmp_field("dest_node", 32'(due.dest_node), 32'(out_data.dest_node));
                    cmp_field("out_clock", due.out_clock, out_data.out_clock);
                    cmp_field("last", 32'(due.last), 32'(out_data.last));
                end
            end
        end
    end

    // command driver
    always @(negedge clk) begin : driver
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            nxt_valid = 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
        end
        if (!nxt_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmds_pending.size() > 0) begin
                nxt_data  = cmds_pending.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // result receiver stall
    always @(negedge clk) begin : receiver
        logic nxt;
        nxt = 1'b0;
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            nxt = 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
        end else if (!quiet) begin
            case ($urandom_range(0, 15))
                0, 1, 2: begin
                    burst_left = $urandom_range(0, 2);
                    nxt = 1'b1;
                end
                3: calm_left = $urandom_range(20, 60);
                default: ;
            endcase
        end
        out_stall <= nxt;
    end

    task automatic push_cmd(input logic [2:0] cmd, input logic [5:0] from,
                            input logic [31:0] mc);
        t_in_item it;
        it.command   = cmd;
        it.from_node = from;
        it.msg_clock = mc;
        cmds_pending.push_back(it);
        cmds_queued++;
    endtask

    task automatic settle_inputs();
        do begin
            @(posedge clk);
            #1;
        end while (cmds_pending.size() != 0 || in_valid);
    endtask

    task automatic drain_node();
        settle_inputs();
        while (sends_due.size() != 0) begin
            @(posedge clk);
            #1;
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [5:0] near_id();
        case ($urandom_range(0, 3))
            0:       return cfg_id;
            1:       return cfg_id + 6'd1;
            2:       return cfg_id - 6'd1;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    // one want / reply / release round with random traffic mixed in
    task automatic play_round();
        logic [31:0] st;
        int unsigned need;
        settle_inputs();
        if (node_state != MODE_RELEASED) begin
            if (node_state == MODE_WANTED)
                repeat (live_count()) push_cmd(CMD_REPLY, 6'($urandom_range(0, 63)), 32'd0);
            push_cmd(CMD_RELEASE, 6'($urandom_range(0, 63)), $urandom());
            settle_inputs();
        end
        st   = lamport + 32'd1;
        need = live_count() - 1;
        if ($urandom_range(0, 7) == 0) push_cmd(CMD_RELEASE, near_id(), $urandom());
        push_cmd(CMD_WANT, 6'($urandom_range(0, 63)), $urandom());
        for (int i = 0; i < need; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_cmd(CMD_REQUEST, near_id(), st + 32'($urandom_range(0, 4)) - 32'd2);
                3:       push_cmd(CMD_OTHER, near_id(), 32'($urandom_range(0, 3)));
                4:       push_cmd(3'($urandom_range(0, CMD_CODE_MAX)), 6'($urandom_range(0, 63)),
                                  $urandom());
                default: ;
            endcase
            push_cmd(CMD_REPLY, 6'($urandom_range(0, 63)),
                     ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 3)));
        end
        case ($urandom_range(0, 5))
            0:       repeat (17) push_cmd(CMD_REQUEST, near_id(), $urandom());
            1, 2, 3: repeat ($urandom_range(1, 3)) push_cmd(CMD_REQUEST, near_id(), $urandom());
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) push_cmd(CMD_WANT, near_id(), $urandom());
        if ($urandom_range(0, 9) != 0) push_cmd(CMD_RELEASE, near_id(), $urandom());
    endtask

    task automatic run_phase(input logic [6:0] id_val, input logic [6:0] cnt_val,
                             input bit pressure);
        int unsigned start;
        drain_node();
        write_reg(CFG_MY_NODE, id_val);
        write_reg(CFG_NODE_COUNT, cnt_val);
        settings_used++;
        @(posedge clk);
        #1;
        if (pressure) hold_start = 1'b1;
        start = cmds_queued;
        while (cmds_queued - start < PHASE_CMDS) play_round();
    endtask

    initial begin : stimulus
        logic [31:0] st;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // directed: clock wrap, immediate reply, stray reply, idle release, unknown codes
        push_cmd(CMD_OTHER, 6'd0, 32'hFFFF_FFFF);
        push_cmd(CMD_REQUEST, 6'd1, 32'd0);
        push_cmd(CMD_REPLY, 6'd63, 32'd5);
        push_cmd(CMD_RELEASE, 6'd0, 32'd0);
        for (int c = int'(CMD_OTHER) + 1; c <= int'(CMD_CODE_MAX); c++)
            push_cmd(3'(c), 6'($urandom_range(0, 63)), $urandom());
        settle_inputs();
        // directed: want, ties on the stamp, older request, entry, release
        st = lamport + 32'd1;
        push_cmd(CMD_WANT, 6'd0, 32'd0);
        push_cmd(CMD_WANT, 6'd63, 32'hFFFF_FFFF);
        push_cmd(CMD_REQUEST, 6'd1, st);
        push_cmd(CMD_REQUEST, 6'd0, st);
        push_cmd(CMD_REQUEST, 6'd1, st - 32'd1);
        push_cmd(CMD_REQUEST, 6'd63, 32'hFFFF_FFFF);
        push_cmd(CMD_REPLY, 6'd1, 32'd0);
        push_cmd(CMD_REQUEST, 6'd42, 32'd0);
        push_cmd(CMD_WANT, 6'd5, 32'd7);
        push_cmd(CMD_RELEASE, 6'd0, 32'd0);

        // random rounds under several node settings
        begin : rounds
            int unsigned start;
            start = cmds_queued;
            while (cmds_queued - start < PHASE_CMDS) play_round();
        end
        run_phase(7'd5, 7'd16, 1'b1);
        run_phase(7'd15, 7'd16, 1'b0);
        run_phase(7'd63, 7'd64, 1'b0);
        run_phase(7'd3, 7'd1, 1'b0);
        run_phase(7'h49, 7'd0, 1'b0);
        run_phase(7'd2, 7'd127, 1'b0);
        drain_node();
        quiet = 1'b1;
        run_phase(7'd1, 7'd3, 1'b0);

        drain_node();
        $display("Checked %0d results from %0d commands over %0d node settings.",
                 sends_checked, cmds_taken, settings_used);
        $display("Section entered %0d times; %0d deferrals dropped on a full queue.",
                 entries, dropped);
        if (errs == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
